// File: sv/hvn_pkg.sv
package hvn_pkg;

  localparam int HEIGHT_BITS = 16;
  localparam int HEIGHT_FRAC = 12;
  localparam int GRID_W      = 11;
  localparam int GRID_RESET  = 64;
  localparam int COORD_W     = 10;
  localparam int NORM_W      = 16;

  // per-vertex sums of up to six face normals
  localparam int SUM_W  = 20;
  localparam int MAG_W  = 19;
  // squared length, its root and the root remainder
  localparam int SQ_W   = 40;
  localparam int ROOT_W = 20;
  localparam int SREM_W = ROOT_W + 3;
  // rounded quotient m * 2^14 / L needs 15 bits
  localparam int QB     = 15;
  localparam int DREM_W = ROOT_W + 1;
  localparam int NUM_W  = MAG_W + QB + 1;
  localparam int IT_W   = 5;

  typedef struct packed {
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
    logic [COORD_W-1:0]      row;
    logic [COORD_W-1:0]      col;
    logic                    last;
  } job_t;

  function automatic logic signed [SUM_W-1:0] sext_h(input logic [HEIGHT_BITS-1:0] h);
    return {{(SUM_W-HEIGHT_BITS){h[HEIGHT_BITS-1]}}, h};
  endfunction

endpackage

// File: sv/hvn_in_if.sv
interface hvn_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   req_type;
  logic signed [hvn_pkg::HEIGHT_BITS-1:0] height;

  modport source (output valid, req_type, height, input ready);
  modport sink (input valid, req_type, height, output ready);
endinterface

// File: sv/hvn_out_if.sv
interface hvn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [hvn_pkg::NORM_W-1:0] norm_x;
  logic signed [hvn_pkg::NORM_W-1:0] norm_y;
  logic signed [hvn_pkg::NORM_W-1:0] norm_z;
  logic [hvn_pkg::COORD_W-1:0]       vertex_row;
  logic [hvn_pkg::COORD_W-1:0]       vertex_col;
  logic                              last;

  modport source (output valid, norm_x, norm_y, norm_z, vertex_row, vertex_col, last,
                  input ready);
  modport sink (input valid, norm_x, norm_y, norm_z, vertex_row, vertex_col, last,
                output ready);
endinterface

// File: sv/heightmap_vertex_normals.sv
// height map vertex normals
// in_ch takes one item per transfer: req_type 0 is a height sample in raster
// order, req_type 1 a drain tick. the normal of vertex (r,c) leaves on out_ch
// once sample (r+1,c) has arrived; drain ticks then release the last row, the
// final vertex with last set. samples that arrive while last-row normals are
// pending, and drain ticks with nothing pending, are taken and dropped.
// cfg_we writes grid_size (clamped to 2..MAX_GRID) and restarts the stream;
// write it only while the block is idle.
// the front takes an item only in its idle state, and its pace is bound by
// three reads through the read port of each row memory; after the reads come
// a capture state and, when the item gives a normal, a push state that waits
// for room in the queue; an item that is dropped leaves the front idle.
// the back works on one normal at a time: the squares, the bit-serial square
// root and then the shared divider once for each of the three components;
// it takes a new job from the queue only once it is back in idle.
// reset clears the counters and sets grid_size to 64; the row memories keep
// stale data, which no normal depends on.
// when out_ch stalls the result holds in the output register, a two-entry
// queue between front and back fills, and then in_ch.ready drops.
module heightmap_vertex_normals #(
  parameter int MAX_GRID = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  hvn_in_if.sink                     in_ch,
  hvn_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [hvn_pkg::GRID_W-1:0] cfg_wdata
);

  logic          push_valid, push_ready, pop_valid, pop;
  hvn_pkg::job_t push_data, pop_data;

  hvn_front #(.MAX_GRID(MAX_GRID)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
  );

  hvn_queue #(.DEPTH(2)) u_queue (
    .clk(clk), .rst_n(rst_n), .push_valid(push_valid), .push_ready(push_ready),
    .push_data(push_data), .pop_valid(pop_valid), .pop(pop), .pop_data(pop_data)
  );

  hvn_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(pop_valid), .job_pop(pop), .job(pop_data),
    .out_ch(out_ch)
  );

endmodule

// File: sv/hvn_ram.sv
module hvn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/hvn_front.sv
module hvn_front #(
  parameter int MAX_GRID = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  hvn_in_if.sink                       in_ch,
  input  logic                         cfg_we,
  input  logic [hvn_pkg::GRID_W-1:0]   cfg_wdata,
  output logic                         push_valid,
  input  logic                         push_ready,
  output hvn_pkg::job_t                push_data
);

  localparam int AW = $clog2(MAX_GRID);
  localparam int NW = AW + 1;
  localparam int GW = hvn_pkg::GRID_W;
  localparam int CW = (NW > GW) ? NW : GW;
  localparam int HB = hvn_pkg::HEIGHT_BITS;
  localparam int SW = hvn_pkg::SUM_W;
  localparam int FR = hvn_pkg::HEIGHT_FRAC;
  localparam int CO = hvn_pkg::COORD_W;

  typedef enum logic [2:0] {F_IDLE, F_RD0, F_RD1, F_RD2, F_CAP, F_PUSH} fstate_t;

  function automatic logic [AW-1:0] grid_m1(input logic [GW-1:0] g);
    logic [CW-1:0] gx;
    logic [CW-1:0] n;
    gx = CW'(g);
    if (gx < CW'(2)) n = CW'(2);
    else if (gx > CW'(MAX_GRID)) n = CW'(MAX_GRID);
    else n = gx;
    n = n - CW'(1);
    return n[AW-1:0];
  endfunction

  function automatic logic [CO-1:0] to_coord(input logic [AW-1:0] v);
    logic [AW+CO-1:0] t;
    t = {{CO{1'b0}}, v};
    return t[CO-1:0];
  endfunction

  fstate_t         state_r;
  logic [AW-1:0]   nm1_r;
  logic [AW-1:0]   in_row_r, in_col_r, out_row_r, out_col_r;
  logic [AW-1:0]   c_r, r_r;
  logic [HB-1:0]   h_r;
  logic            drain_r, emit_r, last_r;
  logic [HB-1:0]   up_m1_r, mid_m1_r, a_r, e_r;
  hvn_pkg::job_t   job_r;

  logic [AW-1:0]   raddr;
  logic            wr_en;
  logic [HB-1:0]   up_rd, mid_rd;

  logic                 v_ul, v_ur, v_ll, v_lr;
  logic [2:0]           cnt;
  logic signed [SW-1:0] wa, wb, wd, we_h, wf, wg, wh, sx_n, sz_n, sy_n;

  assign in_ch.ready = (state_r == F_IDLE);
  assign push_valid  = (state_r == F_PUSH);
  assign push_data   = job_r;
  assign wr_en       = (state_r == F_CAP) && !drain_r;

  always_comb begin
    unique case (state_r)
      F_RD0:   raddr = c_r - AW'(1);
      F_RD1:   raddr = c_r;
      F_RD2:   raddr = c_r + AW'(1);
      default: raddr = c_r;
    endcase
  end

  hvn_ram #(.WIDTH(HB), .DEPTH(MAX_GRID)) u_upper (
    .clk(clk), .we(wr_en), .waddr(c_r), .wdata(e_r), .raddr(raddr), .rdata(up_rd)
  );

  hvn_ram #(.WIDTH(HB), .DEPTH(MAX_GRID)) u_middle (
    .clk(clk), .we(wr_en), .waddr(c_r), .wdata(h_r), .raddr(raddr), .rdata(mid_rd)
  );

  // neighborhood sums of the up to six faces around vertex (r,c)
  always_comb begin
    v_ul = (r_r != '0) && (c_r != '0);
    v_ur = (r_r != '0) && (c_r != nm1_r);
    v_ll = (r_r != nm1_r) && (c_r != '0);
    v_lr = (r_r != nm1_r) && (c_r != nm1_r);
    wa   = hvn_pkg::sext_h(a_r);
    wb   = hvn_pkg::sext_h(up_rd);
    wd   = hvn_pkg::sext_h(drain_r ? mid_m1_r : up_m1_r);
    we_h = hvn_pkg::sext_h(e_r);
    wf   = hvn_pkg::sext_h(mid_rd);
    wg   = hvn_pkg::sext_h(mid_m1_r);
    wh   = hvn_pkg::sext_h(h_r);
    sx_n = '0;
    sz_n = '0;
    if (v_ul) begin
      sx_n = sx_n + (we_h - wd);
      sz_n = sz_n + (we_h - wa);
    end
    if (v_ur) begin
      sx_n = sx_n + (wb - wa) + (wf - we_h);
      sz_n = sz_n + (we_h - wa) + (wf - wb);
    end
    if (v_ll) begin
      sx_n = sx_n + (we_h - wd) + (wh - wg);
      sz_n = sz_n + (wg - wd) + (wh - we_h);
    end
    if (v_lr) begin
      sx_n = sx_n + (wf - we_h);
      sz_n = sz_n + (wh - we_h);
    end
    cnt  = {2'b00, v_ul} + {2'b00, v_lr} + {1'b0, v_ur, 1'b0} + {1'b0, v_ll, 1'b0};
    sy_n = -$signed({{(SW-3-FR){1'b0}}, cnt, {FR{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= F_IDLE;
      nm1_r     <= grid_m1(GW'(hvn_pkg::GRID_RESET));
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else if (cfg_we) begin
      nm1_r     <= grid_m1(cfg_wdata);
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            if (!in_ch.req_type) begin
              if (out_row_r != nm1_r) begin
                drain_r <= 1'b0;
                c_r     <= in_col_r;
                r_r     <= in_row_r - AW'(1);
                h_r     <= in_ch.height;
                emit_r  <= (in_row_r != '0);
                last_r  <= 1'b0;
                state_r <= F_RD0;
                if (in_col_r == nm1_r) begin
                  in_col_r <= '0;
                  in_row_r <= (in_row_r == nm1_r) ? '0 : in_row_r + AW'(1);
                end else begin
                  in_col_r <= in_col_r + AW'(1);
                end
                if (in_row_r != '0) begin
                  if (out_col_r == nm1_r) begin
                    out_col_r <= '0;
                    out_row_r <= out_row_r + AW'(1);
                  end else begin
                    out_col_r <= out_col_r + AW'(1);
                  end
                end
              end
            end else if (out_row_r == nm1_r) begin
              drain_r <= 1'b1;
              c_r     <= out_col_r;
              r_r     <= nm1_r;
              emit_r  <= 1'b1;
              last_r  <= (out_col_r == nm1_r);
              state_r <= F_RD0;
              if (out_col_r == nm1_r) begin
                out_col_r <= '0;
                out_row_r <= '0;
              end else begin
                out_col_r <= out_col_r + AW'(1);
              end
            end
          end
        end
        F_RD0: begin
          state_r <= F_RD1;
        end
        F_RD1: begin
          up_m1_r  <= up_rd;
          mid_m1_r <= mid_rd;
          state_r  <= F_RD2;
        end
        F_RD2: begin
          a_r     <= up_rd;
          e_r     <= mid_rd;
          state_r <= F_CAP;
        end
        F_CAP: begin
          job_r.sx   <= sx_n;
          job_r.sy   <= sy_n;
          job_r.sz   <= sz_n;
          job_r.row  <= to_coord(r_r);
          job_r.col  <= to_coord(c_r);
          job_r.last <= last_r;
          state_r    <= emit_r ? F_PUSH : F_IDLE;
        end
        F_PUSH: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

// File: sv/hvn_queue.sv
module hvn_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  hvn_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop,
  output hvn_pkg::job_t pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int KW = $clog2(DEPTH + 1);

  hvn_pkg::job_t slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [KW-1:0] count_r;
  logic          do_push, do_pop;

  assign push_ready = (count_r != KW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_ptr_r] <= push_data;
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) count_r <= count_r + KW'(1);
      else if (do_pop && !do_push) count_r <= count_r - KW'(1);
    end
  end

endmodule

// File: sv/hvn_back.sv
module hvn_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_pop,
  input  hvn_pkg::job_t job,
  hvn_out_if.source     out_ch
);

  localparam int SW  = hvn_pkg::SUM_W;
  localparam int MW  = hvn_pkg::MAG_W;
  localparam int QW  = hvn_pkg::SQ_W;
  localparam int RW  = hvn_pkg::ROOT_W;
  localparam int RMW = hvn_pkg::SREM_W;
  localparam int QB  = hvn_pkg::QB;
  localparam int DW  = hvn_pkg::DREM_W;
  localparam int NMW = hvn_pkg::NUM_W;
  localparam int IW  = hvn_pkg::IT_W;
  localparam int OW  = hvn_pkg::NORM_W;
  localparam int CO  = hvn_pkg::COORD_W;

  typedef enum logic [2:0] {B_IDLE, B_SQ, B_ROOT, B_DLOAD, B_DIV, B_OUT} bstate_t;

  function automatic logic [MW-1:0] mag_of(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] a;
    a = s[SW-1] ? -s : s;
    return a[MW-1:0];
  endfunction

  bstate_t         state_r;
  logic [MW-1:0]   mag_r [3];
  logic [2:0]      neg_r;
  logic [CO-1:0]   row_r, col_r;
  logic            last_r;
  logic [1:0]      k_r;
  logic [2*MW-1:0] prod_r;
  logic [QW-1:0]   acc_r, rad_r;
  logic [RMW-1:0]  rem_r;
  logic [RW-1:0]   root_r;
  logic [DW-1:0]   drem_r;
  logic [QB-1:0]   lo_r, q_r;
  logic [IW-1:0]   it_r;
  logic [OW-1:0]   res_r [3];
  logic            ovalid_r;
  logic [OW-1:0]   onx_r, ony_r, onz_r;
  logic [CO-1:0]   orow_r, ocol_r;
  logic            olast_r;

  logic [MW-1:0]   msel;
  logic            nsel;
  logic [2*MW-1:0] msq;
  logic [RMW-1:0]  remsh, trial;
  logic            rge;
  logic [DW:0]     dsh, dd, ddiff;
  logic            dge;
  logic [QB-1:0]   q_nxt;
  logic [OW-1:0]   qx, res_nxt;
  logic [NMW-1:0]  num;

  assign job_pop       = (state_r == B_IDLE) && job_valid;
  assign out_ch.valid      = ovalid_r;
  assign out_ch.norm_x     = onx_r;
  assign out_ch.norm_y     = ony_r;
  assign out_ch.norm_z     = onz_r;
  assign out_ch.vertex_row = orow_r;
  assign out_ch.vertex_col = ocol_r;
  assign out_ch.last       = olast_r;

  always_comb begin
    case (state_r)
      B_SQ: begin
        case (k_r)
          2'd0:    msel = mag_r[0];
          2'd1:    msel = mag_r[1];
          default: msel = mag_r[2];
        endcase
        nsel = 1'b0;
      end
      default: begin
        case (k_r)
          2'd0:    begin msel = mag_r[0]; nsel = neg_r[0]; end
          2'd1:    begin msel = mag_r[1]; nsel = neg_r[1]; end
          default: begin msel = mag_r[2]; nsel = neg_r[2]; end
        endcase
      end
    endcase
    msq   = msel * msel;
    // digit-by-digit square root, two radicand bits a step
    remsh = {rem_r[RMW-3:0], rad_r[QW-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    rge   = (remsh >= trial);
    // restoring divide of (m * 2^15 + L) by 2L
    num   = NMW'({msel, {QB{1'b0}}}) + NMW'(root_r);
    dsh   = {drem_r, lo_r[QB-1]};
    dd    = {1'b0, root_r, 1'b0};
    dge   = (dsh >= dd);
    ddiff = dsh - dd;
    q_nxt = {q_r[QB-2:0], dge};
    qx    = OW'(q_nxt);
    if (root_r == '0) res_nxt = '0;
    else res_nxt = nsel ? -qx : qx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      if (out_ch.ready && state_r != B_OUT) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            mag_r[0] <= mag_of(job.sx);
            mag_r[1] <= mag_of(job.sy);
            mag_r[2] <= mag_of(job.sz);
            neg_r    <= {job.sz[SW-1], job.sy[SW-1], job.sx[SW-1]};
            row_r    <= job.row;
            col_r    <= job.col;
            last_r   <= job.last;
            k_r      <= '0;
            acc_r    <= '0;
            state_r  <= B_SQ;
          end
        end
        B_SQ: begin
          prod_r <= msq;
          if (k_r != 2'd0) begin
            acc_r <= acc_r + QW'(prod_r);
          end
          if (k_r == 2'd3) begin
            rad_r   <= acc_r + QW'(prod_r);
            rem_r   <= '0;
            root_r  <= '0;
            it_r    <= '0;
            state_r <= B_ROOT;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        B_ROOT: begin
          rad_r  <= {rad_r[QW-3:0], 2'b00};
          rem_r  <= rge ? remsh - trial : remsh;
          root_r <= {root_r[RW-2:0], rge};
          it_r   <= it_r + IW'(1);
          if (it_r == IW'(RW - 1)) begin
            k_r     <= '0;
            state_r <= B_DLOAD;
          end
        end
        B_DLOAD: begin
          drem_r  <= DW'(num[NMW-1:QB]);
          lo_r    <= num[QB-1:0];
          q_r     <= '0;
          it_r    <= '0;
          state_r <= B_DIV;
        end
        B_DIV: begin
          drem_r <= dge ? ddiff[DW-1:0] : dsh[DW-1:0];
          lo_r   <= {lo_r[QB-2:0], 1'b0};
          q_r    <= q_nxt;
          it_r   <= it_r + IW'(1);
          if (it_r == IW'(QB - 1)) begin
            case (k_r)
              2'd0:    res_r[0] <= res_nxt;
              2'd1:    res_r[1] <= res_nxt;
              default: res_r[2] <= res_nxt;
            endcase
            if (k_r == 2'd2) begin
              state_r <= B_OUT;
            end else begin
              k_r     <= k_r + 2'd1;
              state_r <= B_DLOAD;
            end
          end
        end
        B_OUT: begin
          if (!ovalid_r || out_ch.ready) begin
            ovalid_r <= 1'b1;
            onx_r    <= res_r[0];
            ony_r    <= res_r[1];
            onz_r    <= res_r[2];
            orow_r   <= row_r;
            ocol_r   <= col_r;
            olast_r  <= last_r;
            state_r  <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
